/* design/sis_pkg.sv */
// Shared types for the stable insertion sorter: the link that each cell shows
// its neighbors and the control bundle that the top level sends to every cell.
// No dependencies.
package sis_pkg;

    localparam int DATA_W = 32;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic                     valid;
        logic                     gt;     // held value is greater than the broadcast value
        logic signed [DATA_W-1:0] value;
    } t_link;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

/* design/sis_if.sv */
// Handshake interfaces for the input and the result items of the sorter.
// Depends on sis_pkg for the data width.
interface sis_in_if import sis_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface sis_out_if import sis_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflowed;

    modport source (output valid, output sorted_value, output last_out, output overflowed,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflowed,
                    output ready);
endinterface

/* design/sis_cell.sv */
// One cell of the insertion chain: holds a single value and its valid bit.
// Depends on sis_pkg for t_link and t_cell_ctl.
module sis_cell
    import sis_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_link     i_left,
    input  t_link     i_right,
    output t_link     o_link
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_value;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_value;
    logic                     w_gt;

    assign w_gt   = r_valid && (r_value > i_ctl.value);
    assign o_link = '{valid: r_valid, gt: w_gt, value: r_value};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.shift) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_ctl.insert) begin
            // A held value that is not greater stays, which keeps equal values
            // in arrival order. Otherwise the cell takes its left neighbor's
            // value if that one moves up too, or the new value.
            if (!(r_valid && !w_gt) && i_left.valid) begin
                n_valid = 1'b1;
                n_value = i_left.gt ? i_left.value : i_ctl.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

endmodule

/* design/stable_insertion_sorter.sv */
// Stable insertion sorter: a run of signed values comes in one item per cycle;
// each is placed in a chain of CAPACITY cells that compare it against their
// held values in parallel, so the chain stays sorted ascending with equal
// values in arrival order. The item marked final is inserted like the others,
// and then the chain shifts its contents out toward the output register, one
// result per cycle while the sink takes them; during that drain no input
// item is accepted. Values that arrive while all cells are full are dropped
// and every result of that run carries the overflow flag. Depends on sis_pkg,
// sis_if and sis_cell.
module stable_insertion_sorter
    import sis_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sis_in_if.sink    i_in,
    sis_out_if.source o_out
);

    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic      r_state;
    logic      r_ovf;
    logic      r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic      r_out_last;
    logic      r_out_ovf;

    t_link     links [CAPACITY];
    t_cell_ctl w_ctl;
    t_link     w_head;
    t_link     w_tail;
    logic      w_accept;
    logic      w_full;
    logic      w_out_free;
    logic      w_load;
    logic      w_last;

    assign w_full     = links[CAPACITY-1].valid;
    assign i_in.ready = (r_state == ST_FILL);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load     = (r_state == ST_DRAIN) && w_out_free;
    assign w_last     = !links[1].valid;

    assign w_ctl  = '{insert: w_accept && !w_full, shift: w_load, value: i_in.value};
    assign w_head = '{valid: 1'b1, gt: 1'b0, value: '0};
    assign w_tail = '{valid: 1'b0, gt: 1'b0, value: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sis_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  ((g == 0) ? w_head : links[(g == 0) ? 0 : g - 1]),
            .i_right ((g == CAPACITY - 1) ? w_tail : links[(g == CAPACITY - 1) ? g : g + 1]),
            .o_link  (links[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_FILL: begin
                    if (w_accept) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.final_item) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_load && w_last) begin
                        r_state <= ST_FILL;
                        r_ovf   <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_out_value <= links[0].value;
            r_out_last  <= w_last;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.last_out     = r_out_last;
    assign o_out.overflowed   = r_out_ovf;

endmodule
